/* rtl/edge_triggered_pulse_outputs_top_macros.svh */
`ifndef EDGE_TRIGGERED_PULSE_OUTPUTS_TOP_MACROS_SVH
`define EDGE_TRIGGERED_PULSE_OUTPUTS_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ETPO_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ETPO_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/etpo_pkg.sv */
`default_nettype none

package etpo_pkg;

    localparam int FIELD_W           = 16;
    localparam int TICK_SLOT_W       = 16;
    localparam int SLOTS_PER_REG     = 4;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_INDEX_W       = 3;
    localparam int DEFAULT_CHANNELS  = 16;
    localparam int DEFAULT_TICK_BITS = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ENABLE      = 3'd0,
        CFG_POSITIVE    = 3'd1,
        CFG_RISING      = 3'd2,
        CFG_REPORT      = 3'd3,
        CFG_TICKS_0_3   = 3'd4,
        CFG_TICKS_4_7   = 3'd5,
        CFG_TICKS_8_11  = 3'd6,
        CFG_TICKS_12_15 = 3'd7
    } cfg_index_t;

    // What one lane found for the current beat.
    typedef struct packed {
        logic drive;
        logic write_req;
        logic write_val;
    } lane_out_t;

    // Per-lane configuration slice.
    typedef struct packed {
        logic enable;
        logic positive;
        logic rising;
        logic report;
    } lane_cfg_t;

endpackage

`default_nettype wire

/* rtl/etpo_if.sv */
`default_nettype none

interface etpo_cmd_if;
    import etpo_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] command_bits;

    modport source (output valid, output command_bits, input ready);
    modport sink (input valid, input command_bits, output ready);
endinterface

interface etpo_res_if;
    import etpo_pkg::*;

    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] drive_bits;
    logic [FIELD_W-1:0] actual_write_mask;
    logic [FIELD_W-1:0] actual_write_value;

    modport source (
        output valid, output drive_bits, output actual_write_mask,
        output actual_write_value, input ready
    );
    modport sink (
        input valid, input drive_bits, input actual_write_mask,
        input actual_write_value, output ready
    );
endinterface

`default_nettype wire

/* rtl/edge_triggered_pulse_outputs_top.sv */
// A result is registered and appears in the cycle after its command beat is accepted.
// One beat per cycle while the result side does not stall; every channel lane is combinational,
// and the output register takes a new beat in the cycle its old one leaves.
// Reset (rst_n, asynchronous, active low) clears the configuration registers,
// the channel state and the output valid; the block accepts beats right after reset.
`default_nettype none

module edge_triggered_pulse_outputs_top #(
    parameter int CHANNELS  = etpo_pkg::DEFAULT_CHANNELS,
    parameter int TICK_BITS = etpo_pkg::DEFAULT_TICK_BITS
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [etpo_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [etpo_pkg::CFG_DATA_W-1:0]    cfg_data,
    etpo_cmd_if.sink                                command,
    etpo_res_if.source                              result
);
    import etpo_pkg::*;

    logic [FIELD_W-1:0] enable_reg;
    logic [FIELD_W-1:0] positive_reg;
    logic [FIELD_W-1:0] rising_reg;
    logic [FIELD_W-1:0] report_reg;
    logic               step;
    lane_out_t          lanes [CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= '0;
            positive_reg <= '0;
            rising_reg   <= '0;
            report_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ENABLE:   enable_reg   <= cfg_data[FIELD_W-1:0];
                CFG_POSITIVE: positive_reg <= cfg_data[FIELD_W-1:0];
                CFG_RISING:   rising_reg   <= cfg_data[FIELD_W-1:0];
                CFG_REPORT:   report_reg   <= cfg_data[FIELD_W-1:0];
                default:      ;
            endcase
        end
    end

    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_ch
        localparam logic [CFG_INDEX_W-1:0] LenIndex =
            CFG_INDEX_W'(int'(CFG_TICKS_0_3) + g / SLOTS_PER_REG);
        localparam int LenLsb = (g % SLOTS_PER_REG) * TICK_SLOT_W;

        logic [TICK_BITS-1:0] len_reg;
        lane_cfg_t            lane_cfg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                len_reg <= '0;
            end
            else if (cfg_we && (cfg_index == LenIndex))
            begin
                len_reg <= cfg_data[LenLsb +: TICK_BITS];
            end
        end

        assign lane_cfg.enable   = enable_reg[g];
        assign lane_cfg.positive = positive_reg[g];
        assign lane_cfg.rising   = rising_reg[g];
        assign lane_cfg.report   = report_reg[g];

        etpo_lane #(
            .TICK_BITS (TICK_BITS)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (step),
            .cfg       (lane_cfg),
            .pulse_len (len_reg),
            .command   (command.command_bits[g]),
            .result    (lanes[g])
        );
    end

    etpo_merge #(
        .CHANNELS (CHANNELS)
    ) u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (command),
        .res   (result),
        .lanes (lanes),
        .step  (step)
    );

endmodule

`default_nettype wire

/* rtl/etpo_lane.sv */
`default_nettype none

module etpo_lane #(
    parameter int TICK_BITS = etpo_pkg::DEFAULT_TICK_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  step,
    input  wire etpo_pkg::lane_cfg_t   cfg,
    input  wire logic [TICK_BITS-1:0]  pulse_len,
    input  wire logic                  command,
    output etpo_pkg::lane_out_t        result
);
    import etpo_pkg::*;

    logic                 active_reg, active_next;
    logic [TICK_BITS-1:0] ticks_reg, ticks_next;
    logic                 prev_reg;
    logic                 edge_seen;

    always_comb
    begin
        edge_seen   = cfg.rising ? (command && !prev_reg) : (!command && prev_reg);
        active_next = active_reg;
        ticks_next  = ticks_reg;
        result      = '0;
        if (!cfg.enable)
        begin
            result.drive = command;
        end
        else if (!active_reg)
        begin
            result.write_req = edge_seen && cfg.report;
            result.write_val = edge_seen && cfg.report && !cfg.rising;
            if (edge_seen && (pulse_len != '0))
            begin
                active_next  = 1'b1;
                ticks_next   = pulse_len - TICK_BITS'(1);
                result.drive = cfg.positive;
            end
            else
            begin
                result.drive = !cfg.positive;
            end
        end
        else if (ticks_reg != '0)
        begin
            ticks_next   = ticks_reg - TICK_BITS'(1);
            result.drive = cfg.positive;
        end
        else
        begin
            active_next  = 1'b0;
            result.drive = !cfg.positive;
        end
    end

    // A disabled channel keeps its state untouched.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            ticks_reg  <= '0;
            prev_reg   <= 1'b0;
        end
        else if (step && cfg.enable)
        begin
            active_reg <= active_next;
            ticks_reg  <= ticks_next;
            prev_reg   <= command;
        end
    end

endmodule

`default_nettype wire

/* rtl/etpo_merge.sv */
`default_nettype none

module etpo_merge #(
    parameter int CHANNELS = etpo_pkg::DEFAULT_CHANNELS
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    etpo_cmd_if.sink                 cmd,
    etpo_res_if.source               res,
    input  wire etpo_pkg::lane_out_t lanes [CHANNELS],
    output logic                     step
);
    import etpo_pkg::*;

    logic               valid_reg;
    logic [FIELD_W-1:0] drive_reg, drive_next;
    logic [FIELD_W-1:0] wmask_reg, wmask_next;
    logic [FIELD_W-1:0] wval_reg, wval_next;

    // The output register frees up in the same cycle it is taken.
    assign cmd.ready = !valid_reg || res.ready;
    assign step      = cmd.valid && cmd.ready;

    for (genvar g = 0; g < FIELD_W; g++)
    begin : g_bit
        if (g < CHANNELS)
        begin : g_lane
            assign drive_next[g] = lanes[g].drive;
            assign wmask_next[g] = lanes[g].write_req;
            assign wval_next[g]  = lanes[g].write_val;
        end
        else
        begin : g_pass
            assign drive_next[g] = cmd.command_bits[g];
            assign wmask_next[g] = 1'b0;
            assign wval_next[g]  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            drive_reg <= drive_next;
            wmask_reg <= wmask_next;
            wval_reg  <= wval_next;
        end
    end

    assign res.valid              = valid_reg;
    assign res.drive_bits         = drive_reg;
    assign res.actual_write_mask  = wmask_reg;
    assign res.actual_write_value = wval_reg;

endmodule

`default_nettype wire

/* rtl/etpo_checker.sv */
`default_nettype none
`include "edge_triggered_pulse_outputs_top_macros.svh"

module etpo_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] drive_bits,
    input wire logic [15:0] write_mask,
    input wire logic [15:0] write_value
);

    // A write value bit is only ever set where its mask bit requests a write.
    `ETPO_ASSERT_IMP(a_value_in_mask, clk, rst_n, out_valid, (write_value & ~write_mask) == 16'd0, "write value outside write mask")

    // An empty output register never holds off the input.
    `ETPO_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !out_valid, in_ready, "input stalled while output empty")

    // Every accepted beat shows up as a result in the next cycle.
    `ETPO_ASSERT_NXT(a_result_follows, clk, rst_n, in_valid && in_ready, out_valid, "accepted beat produced no result")

    // A stalled result holds.
    `ETPO_ASSERT_NXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(drive_bits) && $stable(write_mask), "stalled result changed")

endmodule

bind edge_triggered_pulse_outputs_top etpo_checker u_etpo_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (command.valid),
    .in_ready    (command.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .drive_bits  (result.drive_bits),
    .write_mask  (result.actual_write_mask),
    .write_value (result.actual_write_value)
);

`default_nettype wire
